### sv/interrupt_priority_task_queue_macros.svh
// Assertion macros for the interrupt priority task queue.
`ifndef INTERRUPT_PRIORITY_TASK_QUEUE_MACROS_SVH
`define INTERRUPT_PRIORITY_TASK_QUEUE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define IPTQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define IPTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/iptq_pkg.sv
// Shared types and constants of the interrupt priority task queue.
package iptq_pkg;

  localparam int DefaultQueueDepth = 16;
  localparam int CfgAddrW          = 5;
  localparam int CfgDataW          = 32;
  localparam int NumVectors        = 3;

  localparam logic [1:0] OpEnqueue   = 2'd0;
  localparam logic [1:0] OpInterrupt = 2'd1;
  localparam logic [1:0] OpDequeue   = 2'd2;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusFull    = 2'd1;
  localparam logic [1:0] StatusBadVect = 2'd2;

  localparam logic [2:0] RegAdcPrio    = 3'd0;
  localparam logic [2:0] RegTimer0Prio = 3'd1;
  localparam logic [2:0] RegTimer1Prio = 3'd2;
  localparam logic [2:0] RegAdcHid     = 3'd3;
  localparam logic [2:0] RegTimer0Hid  = 3'd4;
  localparam logic [2:0] RegTimer1Hid  = 3'd5;

  localparam logic [1:0] VecAdc    = 2'd0;
  localparam logic [1:0] VecTimer0 = 2'd1;
  localparam logic [1:0] VecTimer1 = 2'd2;

  localparam logic [7:0] ResetAdcPrio    = 8'd250;
  localparam logic [7:0] ResetTimer0Prio = 8'd249;
  localparam logic [7:0] ResetTimer1Prio = 8'd248;
  localparam logic [3:0] ResetAdcHid     = 4'd0;
  localparam logic [3:0] ResetTimer0Hid  = 4'd1;
  localparam logic [3:0] ResetTimer1Hid  = 4'd2;

  typedef struct packed {
    logic [1:0] op;
    logic [3:0] handler_id;
    logic [7:0] priority_req;
    logic [2:0] vector;
  } in_t;

  typedef struct packed {
    logic       valid_res;
    logic [3:0] out_handler;
    logic [7:0] out_priority;
    logic [1:0] status;
    logic [4:0] occupancy;
  } out_t;

  typedef struct packed {
    logic [3:0] hid;
    logic [7:0] prio;
  } entry_t;

endpackage

### sv/interrupt_priority_task_queue.sv
// An enqueue steps through a scan and a compare state for each held entry of lower priority,
// moving it one place toward the tail, and then writes the new entry; a dequeue of a held
// entry reads it in a dequeue state. Every transaction ends in a finish state that waits until
// the output is free. One transaction at a time: the input stalls until the queue is idle.
// Reset: count and head pointer clear, registers take defaults; entries are not cleared.
// Top level of the interrupt priority task queue.
`include "interrupt_priority_task_queue_macros.svh"

module interrupt_priority_task_queue
  import iptq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DefaultQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW:0]   DepthW  = (AW+1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DepthC  = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(QUEUE_DEPTH - 1);

  typedef enum logic [2:0] {StIdle, StScan, StCmp, StDeq, StFinish} state_e;

  state_e        state_q;
  logic [CW-1:0] cnt_q;
  logic [AW-1:0] head_q;
  logic [AW-1:0] idx_q;
  entry_t        new_q;
  out_t          res_q;
  out_t          out_q;
  logic          out_valid_q;

  logic [7:0] cfg_prio_q [NumVectors];
  logic [3:0] cfg_hid_q  [NumVectors];

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_q;

  logic          accept;
  logic          cfg_we;
  logic [2:0]    cfg_idx;
  logic [AW-1:0] idx_sel;
  logic [AW:0]   sum;
  logic [AW:0]   phys;
  logic [AW-1:0] addr;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  entry_t        mem_wd;
  logic          rd_ge;
  entry_t        vec_entry;
  logic          out_free;

  function automatic out_t status_res(logic [1:0] st);
    out_t r;
    r        = '0;
    r.status = st;
    return r;
  endfunction

  assign accept      = in_valid_i && (state_q == StIdle);
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign cfg_we      = psel && penable && pwrite;
  assign cfg_idx     = paddr[4:2];
  assign out_free    = !out_valid_q || !out_stall_i;
  assign rd_ge       = (rd_q.prio >= new_q.prio);

  always_comb begin
    idx_sel = idx_q;
    if (state_q == StScan && idx_q != '0) begin
      idx_sel = idx_q - 1'b1;
    end
    sum  = {1'b0, head_q} + {1'b0, idx_sel};
    phys = (sum >= DepthW) ? (sum - DepthW) : sum;
    addr = phys[AW-1:0];
    rd_addr = (state_q == StIdle) ? head_q : addr;
    mem_we = (state_q == StCmp) || (state_q == StScan && idx_q == '0);
    mem_wd = (state_q == StCmp && !rd_ge) ? rd_q : new_q;
  end

  always_comb begin
    case (in_data_i.vector[1:0])
      VecAdc:    vec_entry = '{hid: cfg_hid_q[0], prio: cfg_prio_q[0]};
      VecTimer0: vec_entry = '{hid: cfg_hid_q[1], prio: cfg_prio_q[1]};
      VecTimer1: vec_entry = '{hid: cfg_hid_q[2], prio: cfg_prio_q[2]};
      default:   vec_entry = '{hid: cfg_hid_q[0], prio: cfg_prio_q[0]};
    endcase
  end

  always_comb begin
    case (cfg_idx)
      RegAdcPrio:    prdata = CfgDataW'(cfg_prio_q[0]);
      RegTimer0Prio: prdata = CfgDataW'(cfg_prio_q[1]);
      RegTimer1Prio: prdata = CfgDataW'(cfg_prio_q[2]);
      RegAdcHid:     prdata = CfgDataW'(cfg_hid_q[0]);
      RegTimer0Hid:  prdata = CfgDataW'(cfg_hid_q[1]);
      RegTimer1Hid:  prdata = CfgDataW'(cfg_hid_q[2]);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr] <= mem_wd;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_prio_q[0] <= ResetAdcPrio;
      cfg_prio_q[1] <= ResetTimer0Prio;
      cfg_prio_q[2] <= ResetTimer1Prio;
      cfg_hid_q[0]  <= ResetAdcHid;
      cfg_hid_q[1]  <= ResetTimer0Hid;
      cfg_hid_q[2]  <= ResetTimer1Hid;
    end else if (cfg_we) begin
      case (cfg_idx)
        RegAdcPrio:    cfg_prio_q[0] <= pwdata[7:0];
        RegTimer0Prio: cfg_prio_q[1] <= pwdata[7:0];
        RegTimer1Prio: cfg_prio_q[2] <= pwdata[7:0];
        RegAdcHid:     cfg_hid_q[0]  <= pwdata[3:0];
        RegTimer0Hid:  cfg_hid_q[1]  <= pwdata[3:0];
        RegTimer1Hid:  cfg_hid_q[2]  <= pwdata[3:0];
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      head_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      new_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != StFinish) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            idx_q <= cnt_q[AW-1:0];
            case (in_data_i.op)
              OpEnqueue: begin
                new_q <= '{hid: in_data_i.handler_id, prio: in_data_i.priority_req};
                if (cnt_q == DepthC) begin
                  res_q   <= status_res(StatusFull);
                  state_q <= StFinish;
                end else begin
                  res_q   <= status_res(StatusOk);
                  state_q <= StScan;
                end
              end
              OpInterrupt: begin
                new_q <= vec_entry;
                if (in_data_i.vector >= 3'(NumVectors)) begin
                  res_q   <= status_res(StatusBadVect);
                  state_q <= StFinish;
                end else if (cnt_q == DepthC) begin
                  res_q   <= status_res(StatusFull);
                  state_q <= StFinish;
                end else begin
                  res_q   <= status_res(StatusOk);
                  state_q <= StScan;
                end
              end
              OpDequeue: begin
                res_q   <= status_res(StatusOk);
                state_q <= (cnt_q != '0) ? StDeq : StFinish;
              end
              default: begin
                res_q   <= status_res(StatusOk);
                state_q <= StFinish;
              end
            endcase
          end
        end
        StScan: begin
          if (idx_q == '0) begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= StFinish;
          end else begin
            state_q <= StCmp;
          end
        end
        StCmp: begin
          if (rd_ge) begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= StFinish;
          end else begin
            idx_q   <= idx_q - 1'b1;
            state_q <= StScan;
          end
        end
        StDeq: begin
          res_q   <= '{valid_res: 1'b1, out_handler: rd_q.hid, out_priority: rd_q.prio,
                       status: StatusOk, occupancy: 5'd0};
          head_q  <= (head_q == LastIdx) ? '0 : head_q + 1'b1;
          cnt_q   <= cnt_q - 1'b1;
          state_q <= StFinish;
        end
        StFinish: begin
          if (out_free) begin
            out_q       <= '{valid_res: res_q.valid_res, out_handler: res_q.out_handler,
                             out_priority: res_q.out_priority, status: res_q.status,
                             occupancy: 5'(cnt_q)};
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `IPTQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= DepthC, "entry count above depth")
  `IPTQ_ASSERT_NOW(a_scan_not_full, state_q == StScan || state_q == StCmp,
                   cnt_q < DepthC, "insert scan on a full queue")
  `IPTQ_ASSERT_NEXT(a_deq_count, state_q == StDeq, cnt_q == $past(cnt_q) - 1'b1,
                    "dequeue did not drop the count")
  `IPTQ_ASSERT_NOW(a_valid_ok, out_valid_o && out_data_o.valid_res,
                   out_data_o.status == StatusOk, "dequeued entry with error status")
  `IPTQ_ASSERT_NOW(a_full_occ, out_valid_o && out_data_o.status == StatusFull,
                   out_data_o.occupancy == 5'(QUEUE_DEPTH), "full status without full occupancy")

endmodule

### verif/tb_interrupt_priority_task_queue.sv
// Testbench for the interrupt priority task queue: predicts every dispatch result and checks it.
`timescale 1ns / 1ps

module tb_interrupt_priority_task_queue;
  import iptq_pkg::*;

  localparam int          Depth      = DefaultQueueDepth;
  localparam int          CycleLimit = 1000000;
  localparam int          PhaseItems = 160;
  localparam int          TailCycles = 2 * Depth + 8;
  localparam logic [1:0]  OpNop      = 2'd3;
  localparam logic [2:0]  RegSpare   = 3'd6;

  class queue_scoreboard;
    int unsigned depth;
    entry_t      held[$];
    logic [7:0]  vec_prio[NumVectors];
    logic [3:0]  vec_hid[NumVectors];
    out_t        pending_results[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned full_drops;
    int unsigned empty_pops;
    int unsigned bad_vectors;
    int unsigned dequeued;

    function new(int unsigned queue_depth);
      depth = queue_depth;
      vec_prio[VecAdc]    = ResetAdcPrio;
      vec_prio[VecTimer0] = ResetTimer0Prio;
      vec_prio[VecTimer1] = ResetTimer1Prio;
      vec_hid[VecAdc]     = ResetAdcHid;
      vec_hid[VecTimer0]  = ResetTimer0Hid;
      vec_hid[VecTimer1]  = ResetTimer1Hid;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        RegAdcPrio:    vec_prio[VecAdc]    = value[7:0];
        RegTimer0Prio: vec_prio[VecTimer0] = value[7:0];
        RegTimer1Prio: vec_prio[VecTimer1] = value[7:0];
        RegAdcHid:     vec_hid[VecAdc]     = value[3:0];
        RegTimer0Hid:  vec_hid[VecTimer0]  = value[3:0];
        RegTimer1Hid:  vec_hid[VecTimer1]  = value[3:0];
        default: ;
      endcase
    endfunction

    function logic [1:0] insert_entry(logic [3:0] hid, logic [7:0] prio);
      entry_t e;
      int     pos;
      if (held.size() >= depth) begin
        full_drops++;
        return StatusFull;
      end
      pos = 0;
      while (pos < held.size() && held[pos].prio >= prio) pos++;
      e.hid  = hid;
      e.prio = prio;
      held.insert(pos, e);
      return StatusOk;
    endfunction

    function void note_request(in_t req);
      out_t res;
      res = '0;
      case (req.op)
        OpEnqueue: res.status = insert_entry(req.handler_id, req.priority_req);
        OpInterrupt: begin
          if (req.vector < NumVectors) begin
            res.status = insert_entry(vec_hid[req.vector[1:0]], vec_prio[req.vector[1:0]]);
          end else begin
            res.status = StatusBadVect;
            bad_vectors++;
          end
        end
        OpDequeue: begin
          if (held.size() > 0) begin
            res.valid_res    = 1'b1;
            res.out_handler  = held[0].hid;
            res.out_priority = held[0].prio;
            void'(held.pop_front());
            dequeued++;
          end else begin
            empty_pops++;
          end
        end
        default: ;
      endcase
      res.occupancy = 5'(held.size());
      pending_results.push_back(res);
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_dispatch(out_t got);
      out_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with no transaction outstanding", got));
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (got.valid_res !== want.valid_res)
        report_mismatch($sformatf("result %0d valid_res got %b want %b",
                                  checked, got.valid_res, want.valid_res));
      if (got.out_handler !== want.out_handler)
        report_mismatch($sformatf("result %0d out_handler got %0d want %0d",
                                  checked, got.out_handler, want.out_handler));
      if (got.out_priority !== want.out_priority)
        report_mismatch($sformatf("result %0d out_priority got %0d want %0d",
                                  checked, got.out_priority, want.out_priority));
      if (got.status !== want.status)
        report_mismatch($sformatf("result %0d status got %0d want %0d",
                                  checked, got.status, want.status));
      if (got.occupancy !== want.occupancy)
        report_mismatch($sformatf("result %0d occupancy got %0d want %0d",
                                  checked, got.occupancy, want.occupancy));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_t                 in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_t                out_data_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  queue_scoreboard sb = new(Depth);
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  int cycle_count;

  interrupt_priority_task_queue #(
    .QUEUE_DEPTH(Depth)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) sb.check_dispatch(out_data_o);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles with %0d results outstanding",
             cycle_count, sb.pending_results.size());
    $display("end of test: mismatches");
    $finish;
  end

  function automatic in_t make_request(logic [1:0] op, logic [3:0] hid, logic [7:0] prio,
                                       logic [2:0] vec);
    in_t req;
    req.op           = op;
    req.handler_id   = hid;
    req.priority_req = prio;
    req.vector       = vec;
    return req;
  endfunction

  function automatic in_t random_request(bit fill_bias);
    in_t req;
    int  roll;
    req.handler_id = 4'($urandom_range(15));
    req.vector     = 3'($urandom_range(7));
    case ($urandom_range(2))
      0: req.priority_req = 8'($urandom_range(255));
      1: req.priority_req = 8'($urandom_range(123, 120));
      default: req.priority_req = $urandom_range(1) ? 8'hFF : 8'h00;
    endcase
    roll = $urandom_range(99);
    if (roll < 4) begin
      req.op = OpNop;
    end else if (roll < (fill_bias ? 70 : 35)) begin
      req.op = (roll % 3 == 0) ? OpInterrupt : OpEnqueue;
    end else begin
      req.op = OpDequeue;
    end
    if (req.op == OpInterrupt && $urandom_range(4) != 0) req.vector = 3'($urandom_range(2));
    return req;
  endfunction

  task automatic send_item(input in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(item);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, value);
  endtask

  task automatic program_setting(input int setting);
    logic [31:0] vals[6];
    logic [31:0] shared;
    shared = $urandom;
    foreach (vals[k]) begin
      case (setting)
        1: vals[k] = 32'hFFFF_FFFF;
        2: vals[k] = 32'h0;
        3: vals[k] = (k < NumVectors) ? shared : $urandom;
        default: vals[k] = $urandom;
      endcase
    end
    write_reg(RegAdcPrio,    vals[0]);
    write_reg(RegTimer0Prio, vals[1]);
    write_reg(RegTimer1Prio, vals[2]);
    write_reg(RegAdcHid,     vals[3]);
    write_reg(RegTimer0Hid,  vals[4]);
    write_reg(RegTimer1Hid,  vals[5]);
    if (setting == 1) write_reg(RegSpare, 32'h0000_0000);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    in_t directed[$];
    int  setting;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed.push_back(make_request(OpDequeue,   4'd0,  8'd0,   3'd0));
    directed.push_back(make_request(OpNop,       4'd15, 8'hFF,  3'd7));
    directed.push_back(make_request(OpEnqueue,   4'd15, 8'hFF,  3'd0));
    directed.push_back(make_request(OpEnqueue,   4'd0,  8'h00,  3'd7));
    directed.push_back(make_request(OpEnqueue,   4'd5,  8'hFF,  3'd0));
    for (int v = 0; v < 8; v++) begin
      directed.push_back(make_request(OpInterrupt, 4'd9, 8'd7, 3'(v)));
    end
    directed.push_back(make_request(OpEnqueue,   4'd10, ResetTimer1Prio, 3'd0));
    for (int d = 0; d < 8; d++) directed.push_back(make_request(OpDequeue, 4'd0, 8'd0, 3'd0));
    foreach (directed[k]) send_item(directed[k]);
    wait_drained();

    for (int regime = 0; regime < 3; regime++) begin
      send_idle_pct  = (regime == 0) ? 13 : (regime == 1) ? 73 : 0;
      recv_stall_pct = (regime == 0) ? 73 : (regime == 1) ? 13 : 0;
      for (int ph = 0; ph < 3; ph++) begin
        setting = regime * 3 + ph;
        if (setting > 0) program_setting(setting);
        for (int i = 0; i < PhaseItems; i++) begin
          if (regime == 2 && ph == 0 && i == 20) hold_cycles = 300;
          if (regime == 2 && ph == 1 && i == 80) wait_drained();
          send_item(random_request((i / 40) % 2 == 0));
        end
        wait_drained();
      end
    end

    repeat (TailCycles) @(posedge clk_i);
    $display("checked %0d results: %0d dispatches, %0d dequeues on empty, %0d full drops,",
             sb.checked, sb.dequeued, sb.empty_pops, sb.full_drops);
    $display("%0d ignored vectors, over 9 register settings and three idling mixes",
             sb.bad_vectors);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
